// File: rtl/plsa_pkg.sv
// Shared constants, operation codes and command/status types for the PLSA EM block.
// Used by plsa_div, plsa_ctrl, plsa_dp and plsa_em_iteration.
`default_nettype none
package plsa_pkg;

  localparam int USERS      = 64;
  localparam int NEWS_ITEMS = 256;
  localparam int TOPICS     = 8;

  localparam int UW  = 6;
  localparam int NW  = 8;
  localparam int KW  = 3;
  localparam int PW  = 16;
  localparam int SW  = 35;
  localparam int DNW = 32;
  localparam int DDW = 35;

  localparam logic [2:0] FN_WR_NT  = 3'd0;
  localparam logic [2:0] FN_WR_UT  = 3'd1;
  localparam logic [2:0] FN_WR_CK  = 3'd2;
  localparam logic [2:0] FN_EM     = 3'd3;
  localparam logic [2:0] FN_SCORE  = 3'd4;
  localparam logic [2:0] FN_RD_NT  = 3'd5;
  localparam logic [2:0] FN_RD_UT  = 3'd6;
  localparam logic [2:0] FN_UNUSED = 3'd7;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_WR_NT    = 5'd1;
  localparam logic [4:0] OP_WR_UT    = 5'd2;
  localparam logic [4:0] OP_WR_CK    = 5'd3;
  localparam logic [4:0] OP_CLR_CK   = 5'd4;
  localparam logic [4:0] OP_CLR_NS   = 5'd5;
  localparam logic [4:0] OP_EM_INIT  = 5'd6;
  localparam logic [4:0] OP_USR_INIT = 5'd7;
  localparam logic [4:0] OP_CLR_ACC  = 5'd8;
  localparam logic [4:0] OP_DOT      = 5'd9;
  localparam logic [4:0] OP_BAD      = 5'd10;
  localparam logic [4:0] OP_QDIV     = 5'd11;
  localparam logic [4:0] OP_QACC     = 5'd12;
  localparam logic [4:0] OP_UDIV     = 5'd13;
  localparam logic [4:0] OP_UTW      = 5'd14;
  localparam logic [4:0] OP_NDIV     = 5'd15;
  localparam logic [4:0] OP_NTW      = 5'd16;
  localparam logic [4:0] OP_RES      = 5'd17;

  localparam logic [2:0] RES_ZERO   = 3'd0;
  localparam logic [2:0] RES_NT     = 3'd1;
  localparam logic [2:0] RES_UT     = 3'd2;
  localparam logic [2:0] RES_SCORE  = 3'd3;
  localparam logic [2:0] RES_STATUS = 3'd4;

  typedef struct packed {
    logic [4:0]    op;
    logic [2:0]    res;
    logic          load;
    logic [UW-1:0] u;
    logic [NW-1:0] n;
    logic [KW-1:0] k;
  } plsa_cmd_t;

  typedef struct packed {
    logic click;
    logic den_zero;
    logic div_done;
    logic out_free;
  } plsa_stat_t;

endpackage
`default_nettype wire

// File: rtl/plsa_em_iteration.sv
// Top level of the PLSA EM block: joins the controller and the datapath.
// Depends on plsa_pkg, plsa_ctrl, plsa_dp and plsa_div.
//
// After reset the block clears its click map, one entry per cycle, through all 16384 entries
// before it takes the first word. A score query uses the single multiplier, which walks the 8
// topics. An EM command clears the news sums, then per user scans the click row, runs a dot
// product and a division per topic for each clicked pair and renormalizes the user row, then
// renormalizes each of the 2048 news entries; all division uses the one shared divider, which
// produces one quotient bit per cycle. A finished result waits in the output register while
// the next word is accepted.
`default_nettype none
module plsa_em_iteration (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [5:0]  in_user_index,
  input  logic [7:0]  in_news_index,
  input  logic [2:0]  in_topic_index,
  input  logic [15:0] in_prob_value,
  input  logic        in_clicked,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value_out,
  output logic [34:0] out_score,
  output logic        out_status
);
  import plsa_pkg::*;

  plsa_cmd_t  cmd;
  plsa_stat_t st;

  plsa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_user_index  (in_user_index),
    .in_news_index  (in_news_index),
    .in_topic_index (in_topic_index),
    .st             (st),
    .cmd            (cmd)
  );

  plsa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_prob_value (in_prob_value),
    .in_clicked    (in_clicked),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out),
    .out_score     (out_score),
    .out_status    (out_status)
  );

endmodule
`default_nettype wire

// File: rtl/plsa_div.sv
// Iterative restoring divider giving floor(num * 2^16 / den), saturated to 16 bits.
// One quotient bit per cycle; depends on plsa_pkg.
`default_nettype none
module plsa_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [plsa_pkg::DNW-1:0] num,
  input  logic [plsa_pkg::DDW-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic [plsa_pkg::PW-1:0]  quot
);
  import plsa_pkg::*;

  logic           busy_r;
  logic           done_r;
  logic [3:0]     cnt_r;
  logic [DDW-1:0] rem_r;
  logic [DDW-1:0] den_r;
  logic [PW-1:0]  quot_r;
  logic [DDW:0]   rem2;
  logic [DDW:0]   diff;
  logic           ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};
  assign diff = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        if ({{(DDW-DNW){1'b0}}, num} >= den) begin
          quot_r <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= DDW'(num);
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DDW-1:0] : rem2[DDW-1:0];
        quot_r <= {quot_r[PW-2:0], ge};
        cnt_r  <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// File: rtl/plsa_ctrl.sv
// Controller state machine: input handshake, clearing pass, table access, score and EM sequencing.
// Drives plsa_dp through plsa_pkg command and status structs.
`default_nettype none
module plsa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_func,
  input  logic [5:0]             in_user_index,
  input  logic [7:0]             in_news_index,
  input  logic [2:0]             in_topic_index,
  input  plsa_pkg::plsa_stat_t   st,
  output plsa_pkg::plsa_cmd_t    cmd
);
  import plsa_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_DOT   = 5'd4;
  localparam logic [4:0] S_DW1   = 5'd5;
  localparam logic [4:0] S_DW2   = 5'd6;
  localparam logic [4:0] S_RES   = 5'd7;
  localparam logic [4:0] S_EMI   = 5'd8;
  localparam logic [4:0] S_NSCLR = 5'd9;
  localparam logic [4:0] S_UBEG  = 5'd10;
  localparam logic [4:0] S_CKRD  = 5'd11;
  localparam logic [4:0] S_CKCHK = 5'd12;
  localparam logic [4:0] S_DEN   = 5'd13;
  localparam logic [4:0] S_QDIV  = 5'd14;
  localparam logic [4:0] S_QWAIT = 5'd15;
  localparam logic [4:0] S_QACC  = 5'd16;
  localparam logic [4:0] S_UDIV  = 5'd17;
  localparam logic [4:0] S_UWAIT = 5'd18;
  localparam logic [4:0] S_UTW   = 5'd19;
  localparam logic [4:0] S_NRD   = 5'd20;
  localparam logic [4:0] S_NDIV  = 5'd21;
  localparam logic [4:0] S_NWAIT = 5'd22;
  localparam logic [4:0] S_NTW   = 5'd23;

  logic [4:0]    state_r, state_nxt;
  logic [2:0]    func_r, func_nxt;
  logic          ok_r, ok_nxt;
  logic [UW-1:0] u_r, u_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          u_last, n_last, k_last;
  logic          uok, nok, tok;

  assign u_last = u_r == UW'(USERS - 1);
  assign n_last = n_r == NW'(NEWS_ITEMS - 1);
  assign k_last = k_r == KW'(TOPICS - 1);
  assign uok = int'(in_user_index) < USERS;
  assign nok = int'(in_news_index) < NEWS_ITEMS;
  assign tok = int'(in_topic_index) < TOPICS;

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    ok_nxt    = ok_r;
    u_nxt     = u_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.res   = RES_ZERO;
    cmd.load  = 1'b0;
    cmd.u     = u_r;
    cmd.n     = n_r;
    cmd.k     = k_r;
    case (state_r)
      S_INIT: begin
        cmd.op = OP_CLR_CK;
        if (n_last) begin
          n_nxt = '0;
          if (u_last) begin
            u_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            u_nxt = u_r + 1'b1;
          end
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = OP_CLR_ACC;
        if (in_valid) begin
          cmd.load = 1'b1;
          func_nxt = in_func;
          u_nxt    = in_user_index;
          n_nxt    = in_news_index;
          k_nxt    = (in_func == FN_SCORE) ? '0 : in_topic_index;
          case (in_func)
            FN_WR_NT, FN_RD_NT: ok_nxt = nok && tok;
            FN_WR_UT, FN_RD_UT: ok_nxt = uok && tok;
            FN_WR_CK, FN_SCORE: ok_nxt = uok && nok;
            default:            ok_nxt = 1'b1;
          endcase
          case (in_func)
            FN_EM:                        state_nxt = S_EMI;
            FN_SCORE:                     state_nxt = (uok && nok) ? S_DOT : S_RES;
            FN_RD_NT, FN_RD_UT:           state_nxt = S_RD;
            FN_WR_NT, FN_WR_UT, FN_WR_CK: state_nxt = S_WR;
            default:                      state_nxt = S_RES;
          endcase
        end
      end
      S_WR: begin
        if (ok_r) begin
          case (func_r)
            FN_WR_NT: cmd.op = OP_WR_NT;
            FN_WR_UT: cmd.op = OP_WR_UT;
            FN_WR_CK: cmd.op = OP_WR_CK;
            default:  cmd.op = OP_NONE;
          endcase
        end
        state_nxt = S_RES;
      end
      S_RD: state_nxt = S_RES;
      S_DOT: begin
        cmd.op = OP_DOT;
        if (k_last) begin
          state_nxt = S_DW1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DW1: state_nxt = S_DW2;
      S_DW2: state_nxt = (func_r == FN_EM) ? S_DEN : S_RES;
      S_RES: begin
        if (st.out_free) begin
          cmd.op = OP_RES;
          case (func_r)
            FN_EM:    cmd.res = RES_STATUS;
            FN_SCORE: cmd.res = ok_r ? RES_SCORE : RES_ZERO;
            FN_RD_NT: cmd.res = ok_r ? RES_NT : RES_ZERO;
            FN_RD_UT: cmd.res = ok_r ? RES_UT : RES_ZERO;
            default:  cmd.res = RES_ZERO;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_EMI: begin
        cmd.op    = OP_EM_INIT;
        n_nxt     = '0;
        k_nxt     = '0;
        state_nxt = S_NSCLR;
      end
      S_NSCLR: begin
        cmd.op = OP_CLR_NS;
        if (k_last) begin
          k_nxt = '0;
          if (n_last) begin
            n_nxt     = '0;
            u_nxt     = '0;
            state_nxt = S_UBEG;
          end else begin
            n_nxt = n_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UBEG: begin
        cmd.op    = OP_USR_INIT;
        state_nxt = S_CKRD;
      end
      S_CKRD: state_nxt = S_CKCHK;
      S_CKCHK: begin
        k_nxt = '0;
        if (st.click) begin
          cmd.op    = OP_CLR_ACC;
          state_nxt = S_DOT;
        end else if (n_last) begin
          state_nxt = S_UDIV;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_CKRD;
        end
      end
      S_DEN: begin
        k_nxt = '0;
        if (st.den_zero) begin
          cmd.op = OP_BAD;
          if (n_last) begin
            state_nxt = S_UDIV;
          end else begin
            n_nxt     = n_r + 1'b1;
            state_nxt = S_CKRD;
          end
        end else begin
          state_nxt = S_QDIV;
        end
      end
      S_QDIV: begin
        cmd.op    = OP_QDIV;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: if (st.div_done) state_nxt = S_QACC;
      S_QACC: begin
        cmd.op = OP_QACC;
        if (k_last) begin
          k_nxt = '0;
          if (n_last) begin
            state_nxt = S_UDIV;
          end else begin
            n_nxt     = n_r + 1'b1;
            state_nxt = S_CKRD;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_QDIV;
        end
      end
      S_UDIV: begin
        cmd.op    = OP_UDIV;
        state_nxt = S_UWAIT;
      end
      S_UWAIT: if (st.div_done) state_nxt = S_UTW;
      S_UTW: begin
        cmd.op = OP_UTW;
        if (k_last) begin
          k_nxt = '0;
          n_nxt = '0;
          if (u_last) begin
            state_nxt = S_NRD;
          end else begin
            u_nxt     = u_r + 1'b1;
            state_nxt = S_UBEG;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_UDIV;
        end
      end
      S_NRD: state_nxt = S_NDIV;
      S_NDIV: begin
        cmd.op    = OP_NDIV;
        state_nxt = S_NWAIT;
      end
      S_NWAIT: if (st.div_done) state_nxt = S_NTW;
      S_NTW: begin
        cmd.op = OP_NTW;
        if (n_last) begin
          n_nxt = '0;
          if (k_last) begin
            state_nxt = S_RES;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_NRD;
          end
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_NRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      func_r  <= FN_WR_NT;
      ok_r    <= 1'b0;
      u_r     <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      func_r  <= func_nxt;
      ok_r    <= ok_nxt;
      u_r     <= u_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/plsa_dp.sv
// Datapath: table, click and sum memories, dot-product multiplier, accumulators,
// shared divider and the output word register. Depends on plsa_pkg and plsa_div.
`default_nettype none
module plsa_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plsa_pkg::plsa_cmd_t   cmd,
  input  logic [15:0]           in_prob_value,
  input  logic                  in_clicked,
  output plsa_pkg::plsa_stat_t  st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_value_out,
  output logic [34:0]           out_score,
  output logic                  out_status
);
  import plsa_pkg::*;

  logic [PW-1:0] nt_mem [0:NEWS_ITEMS*TOPICS-1];
  logic [PW-1:0] ut_mem [0:USERS*TOPICS-1];
  logic          ck_mem [0:USERS*NEWS_ITEMS-1];
  logic [23:0]   ns_mem [0:NEWS_ITEMS*TOPICS-1];

  logic [NW+KW-1:0] nt_addr;
  logic [UW+KW-1:0] ut_addr;
  logic [UW+NW-1:0] ck_addr;
  logic [PW-1:0]    nt_q, ut_q, nt_wd, ut_wd;
  logic [23:0]      ns_q, ns_wd;
  logic             ck_q, ck_wd;
  logic             nt_we, ut_we, ck_we, ns_we;

  logic [PW-1:0] pv_r;
  logic          ck_r;
  logic          dot_d1_r, dot_d2_r;
  logic [KW-1:0] k_d1_r, k_d2_r;
  logic [31:0]   mul_r;
  logic [SW-1:0] acc_r;
  logic [SW:0]   acc_sum;
  logic [31:0]   prod_r [0:TOPICS-1];
  logic [31:0]   ttot_r [0:TOPICS-1];
  logic [23:0]   usum_r [0:TOPICS-1];
  logic [23:0]   utot_r;
  logic          bad_r;
  logic [24:0]   ns_sum, usum_sum, utot_sum;
  logic [32:0]   ttot_sum;
  logic          ttot_zero, utot_zero;

  logic           div_start, div_busy, div_done;
  logic [DNW-1:0] div_num;
  logic [DDW-1:0] div_den;
  logic [PW-1:0]  quot;

  logic          out_valid_r;
  logic [PW-1:0] out_value_r;
  logic [SW-1:0] out_score_r;
  logic          out_status_r;

  assign nt_addr = {cmd.n, cmd.k};
  assign ut_addr = {cmd.u, cmd.k};
  assign ck_addr = {cmd.u, cmd.n};

  assign ttot_zero = ttot_r[cmd.k] == '0;
  assign utot_zero = utot_r == '0;

  assign nt_we = (cmd.op == OP_WR_NT) || (cmd.op == OP_NTW);
  assign nt_wd = (cmd.op == OP_WR_NT) ? pv_r : (ttot_zero ? '0 : quot);
  assign ut_we = (cmd.op == OP_WR_UT) || (cmd.op == OP_UTW);
  assign ut_wd = (cmd.op == OP_WR_UT) ? pv_r : (utot_zero ? '0 : quot);
  assign ck_we = (cmd.op == OP_WR_CK) || (cmd.op == OP_CLR_CK);
  assign ck_wd = (cmd.op == OP_WR_CK) ? ck_r : 1'b0;

  assign ns_sum   = {1'b0, ns_q} + 25'(quot);
  assign usum_sum = {1'b0, usum_r[cmd.k]} + 25'(quot);
  assign utot_sum = {1'b0, utot_r} + 25'(quot);
  assign ttot_sum = {1'b0, ttot_r[cmd.k]} + 33'(quot);
  assign acc_sum  = {1'b0, acc_r} + (SW+1)'(mul_r);

  assign ns_we = (cmd.op == OP_CLR_NS) || (cmd.op == OP_QACC);
  assign ns_wd = (cmd.op == OP_CLR_NS) ? '0 : (ns_sum[24] ? '1 : ns_sum[23:0]);

  always_ff @(posedge clk) begin
    nt_q <= nt_mem[nt_addr];
    if (nt_we) nt_mem[nt_addr] <= nt_wd;
  end

  always_ff @(posedge clk) begin
    ut_q <= ut_mem[ut_addr];
    if (ut_we) ut_mem[ut_addr] <= ut_wd;
  end

  always_ff @(posedge clk) begin
    ck_q <= ck_mem[ck_addr];
    if (ck_we) ck_mem[ck_addr] <= ck_wd;
  end

  always_ff @(posedge clk) begin
    ns_q <= ns_mem[nt_addr];
    if (ns_we) ns_mem[nt_addr] <= ns_wd;
  end

  assign div_start = (cmd.op == OP_QDIV) || (cmd.op == OP_UDIV) || (cmd.op == OP_NDIV);

  always_comb begin
    case (cmd.op)
      OP_QDIV: begin
        div_num = prod_r[cmd.k];
        div_den = acc_r;
      end
      OP_UDIV: begin
        div_num = DNW'(usum_r[cmd.k]);
        div_den = DDW'(utot_r);
      end
      default: begin
        div_num = DNW'(ns_q);
        div_den = DDW'(ttot_r[cmd.k]);
      end
    endcase
  end

  plsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_d1_r <= 1'b0;
      dot_d2_r <= 1'b0;
      bad_r    <= 1'b0;
    end else begin
      dot_d1_r <= cmd.op == OP_DOT;
      dot_d2_r <= dot_d1_r;
      if (cmd.op == OP_EM_INIT) begin
        bad_r <= 1'b0;
      end else if ((cmd.op == OP_BAD) || ((cmd.op == OP_UTW) && utot_zero) ||
                   ((cmd.op == OP_NTW) && ttot_zero)) begin
        bad_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_d1_r <= cmd.k;
    k_d2_r <= k_d1_r;
    if (cmd.load) begin
      pv_r <= in_prob_value;
      ck_r <= in_clicked;
    end
    if (dot_d1_r) mul_r <= nt_q * ut_q;
    if (cmd.op == OP_CLR_ACC) begin
      acc_r <= '0;
    end else if (dot_d2_r) begin
      acc_r <= acc_sum[SW] ? '1 : acc_sum[SW-1:0];
      prod_r[k_d2_r] <= mul_r;
    end
    if (cmd.op == OP_EM_INIT) begin
      for (int i = 0; i < TOPICS; i++) ttot_r[i] <= '0;
    end else if (cmd.op == OP_QACC) begin
      ttot_r[cmd.k] <= ttot_sum[32] ? '1 : ttot_sum[31:0];
    end
    if (cmd.op == OP_USR_INIT) begin
      for (int i = 0; i < TOPICS; i++) usum_r[i] <= '0;
      utot_r <= '0;
    end else if (cmd.op == OP_QACC) begin
      usum_r[cmd.k] <= usum_sum[24] ? '1 : usum_sum[23:0];
      utot_r        <= utot_sum[24] ? '1 : utot_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_RES) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RES) begin
      out_value_r  <= (cmd.res == RES_NT) ? nt_q : ((cmd.res == RES_UT) ? ut_q : '0);
      out_score_r  <= (cmd.res == RES_SCORE) ? acc_r : '0;
      out_status_r <= (cmd.res == RES_STATUS) ? bad_r : 1'b0;
    end
  end

  assign st.click    = ck_q;
  assign st.den_zero = acc_r == '0;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_score     = out_score_r;
  assign out_status    = out_status_r;

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RES) |-> (!out_valid_r || out_ready))
    else $error("Result issued while the output word is still held.");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("Divider started while busy.");

  a_div_idle_use: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_QACC) || (cmd.op == OP_UTW) || (cmd.op == OP_NTW)) |-> !div_busy)
    else $error("Quotient used before the divider finished.");

endmodule
`default_nettype wire
